>>> sv/bdc_pkg.sv
package bdc_pkg;

   // Event codes carried in event_code
   localparam logic [3:0] EV_NONE    = 4'd0;
   localparam logic [3:0] EV_PRESS   = 4'd1;
   localparam logic [3:0] EV_RELEASE = 4'd2;
   localparam logic [3:0] EV_CLICK1  = 4'd3;
   localparam logic [3:0] EV_CLICK2  = 4'd4;
   localparam logic [3:0] EV_CLICK3  = 4'd5;
   localparam logic [3:0] EV_LONG1   = 4'd6;
   localparam logic [3:0] EV_LONG2   = 4'd7;
   localparam logic [3:0] EV_LONG3   = 4'd8;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TIME    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_GAP_TIME   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_LONG_TIME  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_LONG_TIME = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THIRD_LONG_TIME  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW       = 3'd5;

   typedef struct packed {
      logic        raw_level;
      logic [31:0] now_time;
      logic        fetch_event;
   } bdc_req_type;

   typedef struct packed {
      logic [3:0] event_code;
      logic       is_pressed;
   } bdc_rsp_type;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] click_gap_time;
      logic [15:0] first_long_time;
      logic [15:0] second_long_time;
      logic [15:0] third_long_time;
      logic        active_low;
   } bdc_cfg_type;

   typedef struct packed {
      logic        last_raw;
      logic        stable_level;
      logic        previous_stable;
      logic [31:0] last_change_time;
      logic [31:0] press_start_time;
      logic [2:0]  long_fired;
      logic [1:0]  click_count;
      logic [31:0] click_deadline;
      logic [3:0]  pending_event;
   } bdc_state_type;

   // One-slot latch: keep the first event until fetched
   function automatic logic [3:0] raise_event(input logic [3:0] pending,
                                              input logic [3:0] code);
      return (pending == EV_NONE) ? code : pending;
   endfunction

endpackage

>>> sv/bdc_csr.sv
module bdc_csr
   import bdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,
   output bdc_cfg_type            cfg
);

   bdc_cfg_type cfg_ff;

   // Load defaults on reset, then take writes; unlisted indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time    <= 16'd50;
         cfg_ff.click_gap_time   <= 16'd300;
         cfg_ff.first_long_time  <= 16'd800;
         cfg_ff.second_long_time <= 16'd2000;
         cfg_ff.third_long_time  <= 16'd5000;
         cfg_ff.active_low       <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE_TIME:    cfg_ff.debounce_time    <= csr_data;
            CSR_CLICK_GAP_TIME:   cfg_ff.click_gap_time   <= csr_data;
            CSR_FIRST_LONG_TIME:  cfg_ff.first_long_time  <= csr_data;
            CSR_SECOND_LONG_TIME: cfg_ff.second_long_time <= csr_data;
            CSR_THIRD_LONG_TIME:  cfg_ff.third_long_time  <= csr_data;
            CSR_ACTIVE_LOW:       cfg_ff.active_low       <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/bdc_step.sv
module bdc_step
   import bdc_pkg::*;
(
   input  bdc_cfg_type   cfg,
   input  bdc_state_type state,
   input  bdc_req_type   req,
   output bdc_state_type state_in,
   output bdc_rsp_type   rsp
);

   logic [2:0][15:0] long_limit;
   logic             settled;
   logic             pressed;
   logic [31:0]      held;
   bdc_state_type    nxt;

   assign long_limit[0] = cfg.first_long_time;
   assign long_limit[1] = cfg.second_long_time;
   assign long_limit[2] = cfg.third_long_time;

   always_comb begin
      nxt = state;

      // Restart the debounce window on any raw edge
      if (req.raw_level != state.last_raw) begin
         nxt.last_raw         = req.raw_level;
         nxt.last_change_time = req.now_time;
      end
      settled = (req.now_time - nxt.last_change_time) >= {16'd0, cfg.debounce_time};
      if (settled) begin
         nxt.stable_level = nxt.last_raw;
      end
      pressed = nxt.stable_level ^ cfg.active_low;

      // Report press or release on a stable edge
      if (nxt.stable_level != state.previous_stable) begin
         nxt.previous_stable = nxt.stable_level;
         if (pressed) begin
            nxt.press_start_time = req.now_time;
            nxt.long_fired       = 3'b000;
            nxt.pending_event    = raise_event(nxt.pending_event, EV_PRESS);
         end else begin
            nxt.pending_event = raise_event(nxt.pending_event, EV_RELEASE);
            if (!nxt.long_fired[0]) begin
               if (nxt.click_count != 2'd3) begin
                  nxt.click_count = nxt.click_count + 2'd1;
               end
               nxt.click_deadline = req.now_time + {16'd0, cfg.click_gap_time};
            end else begin
               nxt.click_count    = 2'd0;
               nxt.click_deadline = 32'd0;
            end
         end
      end

      held = req.now_time - nxt.press_start_time;

      if (pressed) begin
         // Fire each hold threshold once per press
         for (int i = 0; i < 3; i++) begin
            if (!nxt.long_fired[i] && (held >= {16'd0, long_limit[i]})) begin
               nxt.long_fired[i] = 1'b1;
               nxt.pending_event = raise_event(nxt.pending_event, EV_LONG1 + 4'(i));
            end
         end
         if (nxt.long_fired[0]) begin
            nxt.click_count    = 2'd0;
            nxt.click_deadline = 32'd0;
         end
      end else if ((nxt.click_deadline != 32'd0) && (req.now_time >= nxt.click_deadline)) begin
         // Gap expired: report the click count
         case (nxt.click_count)
            2'd0: ;
            2'd1: nxt.pending_event = raise_event(nxt.pending_event, EV_CLICK1);
            2'd2: nxt.pending_event = raise_event(nxt.pending_event, EV_CLICK2);
            default: nxt.pending_event = raise_event(nxt.pending_event, EV_CLICK3);
         endcase
         nxt.click_count    = 2'd0;
         nxt.click_deadline = 32'd0;
      end

      // Fetch reads and clears the latch after the update
      rsp.event_code = req.fetch_event ? nxt.pending_event : EV_NONE;
      rsp.is_pressed = pressed;
      if (req.fetch_event) begin
         nxt.pending_event = EV_NONE;
      end

      state_in = nxt;
   end

endmodule

>>> sv/button_debounce_click_long_press_core.sv
// Button debouncer with press/release, multi-click and three long-press
// events. Each item is one poll: pin level, millisecond time and a fetch
// flag; each poll returns exactly one item with the fetched event (none
// unless fetch_event is set) and the debounced pressed state. One poll is
// taken every cycle unless a stalled result holds the input register; a
// poll is captured in the input register when it is accepted, and its
// result enters the result register once that register is free. The
// whole state update for a poll is combinational logic between those
// registers, which is what sets the one-poll-per-cycle rate. The user
// must write configuration through the csr_ port only while no poll is in flight; the block does not enforce this.
module button_debounce_click_long_press_core
   import bdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdc_req_type            req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdc_rsp_type            rsp_data
);

   bdc_cfg_type   cfg;
   bdc_state_type state_ff;
   bdc_state_type state_in;
   bdc_rsp_type   step_rsp;

   logic          in_valid_ff;
   bdc_req_type   in_data_ff;
   logic          rsp_valid_ff;
   bdc_rsp_type   rsp_data_ff;
   logic          advance;
   logic          step_fire;

   bdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bdc_step u_step (
      .cfg      (cfg),
      .state    (state_ff),
      .req      (in_data_ff),
      .state_in (state_in),
      .rsp      (step_rsp)
   );

   // Result register frees when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Button state advances once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_raw         <= 1'b1;
         state_ff.stable_level     <= 1'b1;
         state_ff.previous_stable  <= 1'b1;
         state_ff.last_change_time <= 32'd0;
         state_ff.press_start_time <= 32'd0;
         state_ff.long_fired       <= 3'b000;
         state_ff.click_count      <= 2'd0;
         state_ff.click_deadline   <= 32'd0;
         state_ff.pending_event    <= EV_NONE;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A processed item always lands in the result register
   a_item_delivered: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid)
      else $error("processed item did not reach the result register");

   // No event is shown for a poll that did not fetch
   a_no_fetch_no_event: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !in_data_ff.fetch_event) |=> (rsp_data.event_code == EV_NONE))
      else $error("event shown without fetch");

   // A fetched item leaves the latch empty
   a_fetch_clears: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_data_ff.fetch_event) |=> (state_ff.pending_event == EV_NONE))
      else $error("pending event not cleared by fetch");

   // Reported event codes stay within the defined set
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.event_code <= EV_LONG3))
      else $error("event code out of range");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
   import bdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes past the end of the map; writes to them must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   bdc_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   bdc_rsp_type            rsp_data;

   // Predicted button state and settings
   bdc_state_type button;
   bdc_cfg_type   setting;

   bdc_req_type poll_queue[$];
   bdc_rsp_type report_queue[$];
   logic [31:0] now_ms;
   int          queued_polls = 0;
   int          accepted_polls = 0;
   int          error_count = 0;
   int          settings_used = 0;
   int          event_tally[16];
   logic        idle_on = 1'b1;
   logic        req_fired = 1'b0;
   int          send_hold = 0;
   int          sink_hold = 0;

   button_debounce_click_long_press_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic pressed_level(input logic level);
      return setting.active_low ? (level == 1'b0) : (level == 1'b1);
   endfunction

   // One-slot latch: keep the first event, drop later ones
   function automatic void post_event(input logic [3:0] code);
      if (button.pending_event == EV_NONE) button.pending_event = code;
   endfunction

   function automatic void clear_clicks();
      button.click_count = 2'd0;
      button.click_deadline = 32'd0;
   endfunction

   // Advance the button state by one poll and return the item it reports
   function automatic bdc_rsp_type track_button(input bdc_req_type poll);
      bdc_rsp_type report;
      logic [31:0] since_change;
      logic [31:0] held;
      logic [15:0] limit;
      logic [3:0]  long_code;
      int          i;
      report = '0;
      if (poll.raw_level != button.last_raw) begin
         button.last_raw = poll.raw_level;
         button.last_change_time = poll.now_time;
      end
      since_change = poll.now_time - button.last_change_time;
      if (since_change >= {16'd0, setting.debounce_time}) button.stable_level = button.last_raw;

      // Edge of the debounced level: press or release
      if (button.stable_level != button.previous_stable) begin
         button.previous_stable = button.stable_level;
         if (pressed_level(button.stable_level)) begin
            button.press_start_time = poll.now_time;
            button.long_fired = 3'b000;
            post_event(EV_PRESS);
         end else begin
            post_event(EV_RELEASE);
            if (!button.long_fired[0]) begin
               if (button.click_count != 2'd3) button.click_count = button.click_count + 2'd1;
               button.click_deadline = poll.now_time + {16'd0, setting.click_gap_time};
            end else begin
               clear_clicks();
            end
         end
      end

      // Hold thresholds while pressed, click deadline while released
      if (pressed_level(button.stable_level)) begin
         held = poll.now_time - button.press_start_time;
         for (i = 0; i < 3; i++) begin
            case (i)
               0: begin
                  limit = setting.first_long_time;
                  long_code = EV_LONG1;
               end
               1: begin
                  limit = setting.second_long_time;
                  long_code = EV_LONG2;
               end
               default: begin
                  limit = setting.third_long_time;
                  long_code = EV_LONG3;
               end
            endcase
            if (!button.long_fired[i] && held >= {16'd0, limit}) begin
               button.long_fired[i] = 1'b1;
               post_event(long_code);
            end
         end
         if (button.long_fired[0]) clear_clicks();
      end else if (button.click_deadline != 32'd0 && poll.now_time >= button.click_deadline) begin
         case (button.click_count)
            2'd1: post_event(EV_CLICK1);
            2'd2: post_event(EV_CLICK2);
            2'd3: post_event(EV_CLICK3);
            default: ;
         endcase
         clear_clicks();
      end

      if (poll.fetch_event) begin
         report.event_code = button.pending_event;
         button.pending_event = EV_NONE;
      end
      report.is_pressed = pressed_level(button.stable_level);
      return report;
   endfunction

   // Drive the poll channel and the result stall at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fired) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (poll_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               send_hold = $urandom_range(0, 13);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= poll_queue.pop_front();
            end
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Predict accepted polls and check results at the rising edge
   always @(posedge clock) begin
      bdc_rsp_type want;
      req_fired = 1'b0;
      if (!reset) begin
         req_fired = req_valid && !req_stall;
         if (req_fired) begin
            report_queue.push_back(track_button(req_data));
            accepted_polls++;
         end
         if (rsp_valid && !rsp_stall) begin
            event_tally[rsp_data.event_code]++;
            if (report_queue.size() == 0) begin
               $display("%0t: result with nothing expected: event_code %0d is_pressed %0d",
                        $time, rsp_data.event_code, rsp_data.is_pressed);
               error_count++;
            end else begin
               want = report_queue.pop_front();
               if (rsp_data.event_code !== want.event_code) begin
                  $display("%0t: event_code mismatch: expected %0d, actual %0d",
                           $time, want.event_code, rsp_data.event_code);
                  error_count++;
               end
               if (rsp_data.is_pressed !== want.is_pressed) begin
                  $display("%0t: is_pressed mismatch: expected %0d, actual %0d",
                           $time, want.is_pressed, rsp_data.is_pressed);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic queue_poll(input logic raw, input logic [31:0] at_ms, input logic fetch);
      bdc_req_type poll;
      poll.raw_level = raw;
      poll.now_time = at_ms;
      poll.fetch_event = fetch;
      now_ms = at_ms;
      poll_queue.push_back(poll);
      queued_polls++;
   endtask

   task automatic queue_step(input logic raw, input int unsigned delta_ms);
      queue_poll(raw, now_ms + delta_ms, $urandom_range(0, 9) < 6);
   endtask

   // One press: bounce, settle, hold, bounce out, then wait short or long
   task automatic queue_episode();
      logic        down_lvl;
      int unsigned db;
      int unsigned gap;
      int unsigned top;
      int unsigned hold;
      int unsigned parts;
      int unsigned bounces;
      down_lvl = !setting.active_low;
      db = {16'd0, setting.debounce_time};
      gap = {16'd0, setting.click_gap_time};
      top = {16'd0, setting.first_long_time};
      if (setting.second_long_time > top) top = {16'd0, setting.second_long_time};
      if (setting.third_long_time > top) top = {16'd0, setting.third_long_time};

      bounces = $urandom_range(0, 3);
      repeat (bounces) begin
         queue_step(down_lvl, $urandom_range(0, db / 2));
         queue_step(!down_lvl, $urandom_range(0, db / 2));
      end
      queue_step(down_lvl, $urandom_range(0, db / 2));
      queue_step(down_lvl, db + $urandom_range(0, 3));

      if ($urandom_range(0, 9) < 7)
         hold = (setting.first_long_time == 0) ? 0 : $urandom_range(0, setting.first_long_time - 1);
      else
         hold = $urandom_range(setting.first_long_time, top + 1000);
      parts = $urandom_range(1, 5);
      repeat (parts) queue_step(down_lvl, hold / parts);

      bounces = $urandom_range(0, 3);
      repeat (bounces) begin
         queue_step(!down_lvl, $urandom_range(0, db / 2));
         queue_step(down_lvl, $urandom_range(0, db / 2));
      end
      queue_step(!down_lvl, $urandom_range(0, db / 2));
      queue_step(!down_lvl, db + $urandom_range(0, 3));
      repeat ($urandom_range(0, 3))
         queue_step(!down_lvl, $urandom_range(0, 1) ? $urandom_range(0, gap / 2)
                                                     : gap + $urandom_range(0, 100));
   endtask

   // Random level, time jump and fetch
   task automatic queue_noise();
      logic [31:0] at_ms;
      at_ms = ($urandom_range(0, 3) == 0) ? $urandom : now_ms + $urandom_range(0, 2000);
      queue_poll(1'($urandom_range(0, 1)), at_ms, 1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input int target);
      int start;
      start = queued_polls;
      while (queued_polls - start < target) begin
         if ($urandom_range(0, 99) < 85) queue_episode();
         else repeat ($urandom_range(1, 3)) queue_noise();
      end
   endtask

   // Hold off until every queued poll is taken and every result is back
   task automatic wait_idle();
      @(negedge clock);
      while (accepted_polls != queued_polls || report_queue.size() != 0) @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         CSR_DEBOUNCE_TIME:    setting.debounce_time = data;
         CSR_CLICK_GAP_TIME:   setting.click_gap_time = data;
         CSR_FIRST_LONG_TIME:  setting.first_long_time = data;
         CSR_SECOND_LONG_TIME: setting.second_long_time = data;
         CSR_THIRD_LONG_TIME:  setting.third_long_time = data;
         CSR_ACTIVE_LOW:       setting.active_low = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] db, input logic [15:0] gap,
                                input logic [15:0] l1, input logic [15:0] l2,
                                input logic [15:0] l3, input logic low);
      logic [15:0] filler;
      filler = 16'($urandom);
      wait_idle();
      write_setting(CSR_DEBOUNCE_TIME, db);
      write_setting(CSR_CLICK_GAP_TIME, gap);
      write_setting(CSR_FIRST_LONG_TIME, l1);
      write_setting(CSR_SECOND_LONG_TIME, l2);
      write_setting(CSR_THIRD_LONG_TIME, l3);
      write_setting(CSR_ACTIVE_LOW, {filler[15:1], low});
      csr_write <= 1'b0;
      settings_used++;
   endtask

   initial begin
      setting.debounce_time = 16'd50;
      setting.click_gap_time = 16'd300;
      setting.first_long_time = 16'd800;
      setting.second_long_time = 16'd2000;
      setting.third_long_time = 16'd5000;
      setting.active_low = 1'b1;
      button = '0;
      button.last_raw = 1'b1;
      button.stable_level = 1'b1;
      button.previous_stable = 1'b1;
      button.pending_event = EV_NONE;
      now_ms = 32'd0;
      settings_used = 1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Long press at reset settings: all three thresholds, latch full drops two
      queue_poll(1'b1, 32'd0, 1'b1);
      queue_poll(1'b0, 32'd10, 1'b0);
      queue_poll(1'b0, 32'd60, 1'b1);
      queue_poll(1'b0, 32'd860, 1'b0);
      queue_poll(1'b0, 32'd2060, 1'b0);
      queue_poll(1'b0, 32'd5060, 1'b1);
      queue_poll(1'b1, 32'd5070, 1'b0);
      queue_poll(1'b1, 32'd5120, 1'b1);

      // No debounce; unmapped indexes must not disturb anything
      wait_idle();
      write_setting(CSR_DEBOUNCE_TIME, 16'd0);
      write_setting(CSR_UNMAPPED_LO, 16'($urandom));
      write_setting(CSR_UNMAPPED_HI, 16'($urandom));
      csr_write <= 1'b0;

      // Four quick clicks saturate the count, then the deadline reports click3
      queue_poll(1'b0, 32'd6000, 1'b1);
      queue_poll(1'b1, 32'd6010, 1'b1);
      queue_poll(1'b0, 32'd6020, 1'b0);
      queue_poll(1'b1, 32'd6030, 1'b0);
      queue_poll(1'b0, 32'd6040, 1'b0);
      queue_poll(1'b1, 32'd6050, 1'b0);
      queue_poll(1'b0, 32'd6060, 1'b0);
      queue_poll(1'b1, 32'd6070, 1'b1);
      queue_poll(1'b1, 32'd6370, 1'b1);

      // Deadline that wraps to zero stays unarmed across the time wrap
      queue_poll(1'b0, 32'hFFFF_FED0, 1'b1);
      queue_poll(1'b1, 32'hFFFF_FED4, 1'b1);
      queue_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
      queue_poll(1'b0, 32'h0000_0000, 1'b1);
      queue_poll(1'b1, 32'h0000_0010, 1'b0);
      // Wrapped small deadline is already passed by the absolute compare
      queue_poll(1'b0, 32'hFFFF_FF00, 1'b1);
      queue_poll(1'b1, 32'hFFFF_FF10, 1'b1);
      queue_poll(1'b1, 32'hFFFF_FF20, 1'b1);

      // Random phases over several settings
      load_settings(16'd5, 16'd40, 16'd100, 16'd250, 16'd600, 1'b0);
      now_ms = $urandom;
      run_phase(300);

      load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      now_ms = $urandom;
      run_phase(300);

      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      now_ms = 32'hFFFF_0000;
      run_phase(300);

      load_settings(16'($urandom_range(0, 80)), 16'($urandom_range(0, 600)),
                    16'($urandom_range(0, 1500)), 16'($urandom_range(0, 3000)),
                    16'($urandom_range(0, 6000)), 1'($urandom_range(0, 1)));
      now_ms = $urandom;
      run_phase(300);

      // Last stretch at reset values with no idling on either side
      load_settings(16'd50, 16'd300, 16'd800, 16'd2000, 16'd5000, 1'b1);
      idle_on = 1'b0;
      now_ms = $urandom;
      run_phase(300);

      wait_idle();
      repeat (20) @(posedge clock);

      $display("Checked %0d polls over %0d register settings with idle bursts on both sides.",
               accepted_polls, settings_used);
      $display("Events seen: press %0d, release %0d, click %0d/%0d/%0d, long %0d/%0d/%0d",
               event_tally[EV_PRESS], event_tally[EV_RELEASE], event_tally[EV_CLICK1],
               event_tally[EV_CLICK2], event_tally[EV_CLICK3], event_tally[EV_LONG1],
               event_tally[EV_LONG2], event_tally[EV_LONG3]);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(64'd5_000_000);
      $display("Timeout with %0d polls taken and %0d results outstanding",
               accepted_polls, report_queue.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
sv/bdc_pkg.sv
sv/bdc_csr.sv
sv/bdc_step.sv
sv/button_debounce_click_long_press_core.sv
tb/testbench.sv
